// ===== rtl/core/counting_semaphore_fifo_waiters_defines.svh =====
// Assertion macros used by the semaphore top level.
`ifndef COUNTING_SEMAPHORE_FIFO_WAITERS_DEFINES_SVH
`define COUNTING_SEMAPHORE_FIFO_WAITERS_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CSFW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("semaphore assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CSFW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("semaphore assertion failed");

`endif

// ===== rtl/core/csfw_pkg.sv =====
// Types and constants of the counting semaphore with a waiter queue.
package csfw_pkg;

    localparam int unsigned DEF_WAIT_DEPTH = 16;
    localparam logic [15:0] DEF_MAX_COUNT  = 16'd1;

    localparam logic [1:0] OP_DOWN = 2'd0;
    localparam logic [1:0] OP_TRY  = 2'd1;
    localparam logic [1:0] OP_UP   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BUSY  = 2'd1;
    localparam logic [1:0] ST_YIELD = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] thread_id;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic       woken_valid;
        logic [7:0] woken_thread;
    } t_rsp;

endpackage

// ===== rtl/core/csfw_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module csfw_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/counting_semaphore_fifo_waiters.sv =====
// Top level: counting semaphore with a FIFO queue of waiting thread ids.
//
//   channel | direction | handshake                   | payload
//   --------+-----------+-----------------------------+------------------------
//   request | in        | i_in_valid / o_in_stall     | i_req (opcode, thread)
//   result  | out       | o_out_valid / i_out_stall   | o_rsp (status, woken)
//   config  | in        | i_cfg_we                    | i_cfg_wdata (max count)
//
// A request that does not pop a waiter is answered straight from S_IDLE; an up
// that wakes a waiter goes through S_POP, as the waiter RAM read is registered.
// The result sits in an output register, so a new request is taken while the
// previous result is being consumed. Reset sets the count to one and empties
// the queue; the queue RAM itself is not cleared. The request side is held
// while a stalled result fills the output register, and also during S_POP.
`include "counting_semaphore_fifo_waiters_defines.svh"

module counting_semaphore_fifo_waiters #(
    parameter int unsigned WAIT_DEPTH = csfw_pkg::DEF_WAIT_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  csfw_pkg::t_req  i_req,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output csfw_pkg::t_rsp  o_rsp,
    input  logic            i_cfg_we,
    input  logic [15:0]     i_cfg_wdata
);

    localparam int unsigned ADDR_W = $clog2(WAIT_DEPTH);
    localparam int unsigned FILL_W = $clog2(WAIT_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_POP  = 2'b10
    } t_state;

    t_state              r_state, n_state;
    logic [15:0]         r_max, n_max;
    logic [15:0]         r_count, n_count;
    logic [ADDR_W-1:0]   r_head, n_head;
    logic [ADDR_W-1:0]   r_tail, n_tail;
    logic [FILL_W-1:0]   r_fill, n_fill;
    logic                r_out_valid, n_out_valid;
    csfw_pkg::t_rsp      r_rsp, n_rsp;

    logic                in_accept;
    logic                ram_we;
    logic                ram_re;
    logic [7:0]          ram_rdata;

    assign o_in_stall  = !((r_state == S_IDLE) && (!r_out_valid || !i_out_stall));
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_rsp       = r_rsp;

    csfw_ram #(
        .WIDTH (8),
        .DEPTH (WAIT_DEPTH)
    ) u_wait_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_tail),
        .i_wdata (i_req.thread_id),
        .i_re    (ram_re),
        .i_raddr (r_head),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_max       = r_max;
        n_count     = r_count;
        n_head      = r_head;
        n_tail      = r_tail;
        n_fill      = r_fill;
        n_rsp       = r_rsp;
        n_out_valid = r_out_valid && i_out_stall;
        ram_we      = 1'b0;
        ram_re      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_out_valid        = 1'b1;
                    n_rsp.status       = csfw_pkg::ST_OK;
                    n_rsp.woken_valid  = 1'b0;
                    n_rsp.woken_thread = 8'd0;
                    unique case (i_req.opcode)
                        csfw_pkg::OP_DOWN: begin
                            if (r_count != 16'd0) begin
                                n_count = r_count - 16'd1;
                            end else if (r_fill == FILL_W'(WAIT_DEPTH)) begin
                                n_rsp.status = csfw_pkg::ST_FULL;
                            end else begin
                                ram_we       = 1'b1;
                                n_tail       = (r_tail == ADDR_W'(WAIT_DEPTH - 1)) ?
                                               '0 : r_tail + 1'b1;
                                n_fill       = r_fill + 1'b1;
                                n_rsp.status = csfw_pkg::ST_YIELD;
                            end
                        end
                        csfw_pkg::OP_TRY: begin
                            if (r_count != 16'd0) begin
                                n_count = r_count - 16'd1;
                            end else begin
                                n_rsp.status = csfw_pkg::ST_BUSY;
                            end
                        end
                        csfw_pkg::OP_UP: begin
                            if (r_count != r_max) begin
                                if (r_fill == '0) begin
                                    n_count = r_count + 16'd1;
                                end else begin
                                    // The woken id arrives from the RAM next cycle.
                                    ram_re      = 1'b1;
                                    n_head      = (r_head == ADDR_W'(WAIT_DEPTH - 1)) ?
                                                  '0 : r_head + 1'b1;
                                    n_fill      = r_fill - 1'b1;
                                    n_out_valid = 1'b0;
                                    n_state     = S_POP;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_POP: begin
                n_out_valid        = 1'b1;
                n_rsp.status       = csfw_pkg::ST_YIELD;
                n_rsp.woken_valid  = 1'b1;
                n_rsp.woken_thread = ram_rdata;
                n_state            = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A register write reloads the count; the queue is left alone.
        if (i_cfg_we) begin
            n_max   = i_cfg_wdata;
            n_count = i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_max       <= csfw_pkg::DEF_MAX_COUNT;
            r_count     <= csfw_pkg::DEF_MAX_COUNT;
            r_head      <= '0;
            r_tail      <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_max       <= n_max;
            r_count     <= n_count;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
    end

    `CSFW_ASSERT_NOW(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= FILL_W'(WAIT_DEPTH))
    `CSFW_ASSERT_NOW(a_pop_after_accept, i_clk, i_rst_n, r_state == S_POP, $past(in_accept))
    `CSFW_ASSERT_NOW(a_woken_is_yield, i_clk, i_rst_n, r_out_valid && r_rsp.woken_valid,
        r_rsp.status == csfw_pkg::ST_YIELD)
    `CSFW_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, in_accept, !r_out_valid || !i_out_stall)

endmodule
